>>> src/qvr_pkg.sv
// Shared widths, latency and types for the quaternion vector rotation core.
package qvr_pkg;

  localparam int DW = 16;
  localparam int QW = 16;
  localparam int SQW = 2 * QW;
  localparam int NW = SQW + 1;
  localparam int MW = SQW + 3;
  localparam int PW = MW + DW;
  localparam int SW = PW + 2;
  localparam int XW = SW + 3;
  localparam int RW = XW - 1;
  localparam int DVW = NW + 1;
  localparam int QB = 17;
  localparam int QSW = QB + 2;
  localparam int LAT = 5 + QB + 1;
  localparam int IN_BITS = 4 * QW + 3 * DW;
  localparam int IN_TW = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TW = ((3 * DW + 7) / 8) * 8;
  localparam int DHI = (1 << (DW - 1)) - 1;

  typedef logic signed [DW-1:0] vec_t [3];

  typedef struct packed {
    logic [NW-1:0] n;
    logic [8:0][MW-1:0] m;
  } mtx_t;

  typedef struct packed {
    logic [RW-1:0] mag;
    logic [DVW-1:0] d;
    logic neg;
    logic zero;
  } divin_t;

endpackage

>>> src/qvr_matrix.sv
// Squared norm and scaled rotation matrix of the quaternion, two register stages.
module qvr_matrix
  import qvr_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  logic signed [QW-1:0] qx,
  input  logic signed [QW-1:0] qy,
  input  logic signed [QW-1:0] qz,
  input  logic signed [QW-1:0] qw,
  input  vec_t v_in,
  output mtx_t mtx,
  output vec_t v_out
);

  logic signed [SQW-1:0] xx, yy, zz, ww, xy, wz, xz, wy, yz, wx;
  logic signed [MW-1:0] exx, eyy, ezz, eww, exy, ewz, exz, ewy, eyz, ewx;
  vec_t v1;

  always_ff @(posedge clk) begin
    if (en) begin
      xx <= qx * qx;
      yy <= qy * qy;
      zz <= qz * qz;
      ww <= qw * qw;
      xy <= qx * qy;
      wz <= qw * qz;
      xz <= qx * qz;
      wy <= qw * qy;
      yz <= qy * qz;
      wx <= qw * qx;
      v1 <= v_in;
    end
  end

  assign exx = MW'(xx);
  assign eyy = MW'(yy);
  assign ezz = MW'(zz);
  assign eww = MW'(ww);
  assign exy = MW'(xy);
  assign ewz = MW'(wz);
  assign exz = MW'(xz);
  assign ewy = MW'(wy);
  assign eyz = MW'(yz);
  assign ewx = MW'(wx);

  always_ff @(posedge clk) begin
    if (en) begin
      mtx.n <= NW'(xx[SQW-2:0]) + NW'(yy[SQW-2:0]) + NW'(zz[SQW-2:0]) + NW'(ww[SQW-2:0]);
      mtx.m[0] <= eww + exx - eyy - ezz;
      mtx.m[1] <= (exy - ewz) <<< 1;
      mtx.m[2] <= (exz + ewy) <<< 1;
      mtx.m[3] <= (exy + ewz) <<< 1;
      mtx.m[4] <= eww - exx + eyy - ezz;
      mtx.m[5] <= (eyz - ewx) <<< 1;
      mtx.m[6] <= (exz - ewy) <<< 1;
      mtx.m[7] <= (eyz + ewx) <<< 1;
      mtx.m[8] <= eww - exx - eyy + ezz;
      v_out <= v1;
    end
  end

endmodule

>>> src/qvr_mac.sv
// Matrix times vector, then the rounding numerator split into sign and magnitude.
module qvr_mac
  import qvr_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  mtx_t mtx,
  input  vec_t v,
  output divin_t dv [3]
);

  logic signed [PW-1:0] p [3][3];
  logic signed [SW-1:0] num [3];
  logic [NW-1:0] n3, n4;
  logic signed [XW-1:0] big [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p[i][j] <= $signed(mtx.m[3*i+j]) * v[j];
        end
      end
      n3 <= mtx.n;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num[i] <= SW'(p[i][0]) + SW'(p[i][1]) + SW'(p[i][2]);
      end
      n4 <= n3;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      big[i] = (XW'(num[i]) <<< 1) + $signed(XW'(n4));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv[i].neg <= big[i][XW-1];
        dv[i].mag <= big[i][XW-1] ? RW'(-big[i]) : RW'(big[i]);
        dv[i].d <= {n4, 1'b0};
        dv[i].zero <= (n4 == '0);
      end
    end
  end

endmodule

>>> src/qvr_div.sv
// One bit per stage restoring divider with floor correction and saturation.
module qvr_div
  import qvr_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  divin_t din,
  output logic signed [DW-1:0] r,
  output logic sat,
  output logic zero
);

  logic [RW-1:0] rem_r [QB];
  logic [QB-1:0] q_r [QB];
  logic [DVW-1:0] d_r [QB];
  logic neg_r [QB];
  logic zero_r [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [RW-1:0] rem_i;
    logic [QB-1:0] q_i;
    logic [DVW-1:0] d_i;
    logic neg_i, zero_i;
    logic [RW-1:0] sh;
    logic ge;

    if (s == 0) begin : g_first
      assign rem_i = din.mag;
      assign q_i = '0;
      assign d_i = din.d;
      assign neg_i = din.neg;
      assign zero_i = din.zero;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign q_i = q_r[s-1];
      assign d_i = d_r[s-1];
      assign neg_i = neg_r[s-1];
      assign zero_i = zero_r[s-1];
    end

    assign sh = RW'(d_i) << (QB - 1 - s);
    assign ge = (rem_i >= sh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? rem_i - sh : rem_i;
        q_r[s] <= {q_i[QB-2:0], ge};
        d_r[s] <= d_i;
        neg_r[s] <= neg_i;
        zero_r[s] <= zero_i;
      end
    end
  end

  logic signed [QSW-1:0] qp, qs;

  always_comb begin
    qp = $signed(QSW'(q_r[QB-1]));
    qs = neg_r[QB-1] ? -qp - QSW'(rem_r[QB-1] != '0) : qp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero <= zero_r[QB-1];
      if (zero_r[QB-1]) begin
        r <= '0;
        sat <= 1'b0;
      end else if (qs > $signed(QSW'(DHI))) begin
        r <= DW'(DHI);
        sat <= 1'b1;
      end else if (qs < -$signed(QSW'(DHI)) - 1) begin
        r <= -DW'(DHI) - 1'b1;
        sat <= 1'b1;
      end else begin
        r <= qs[DW-1:0];
        sat <= 1'b0;
      end
    end
  end

endmodule

>>> src/quaternion_vector_rotate_core.sv
// Top level of the pipelined quaternion vector rotation core.
//
// Channel | Direction | Contents
// s_*     | in        | tdata: qx, qy, qz, qw, vx, vy, vz
// m_*     | out       | tdata: rx, ry, rz; tuser: zero_quat, saturated
//
// A transaction is accepted every cycle while the output is not stalled, and its result passes
// through the matrix, multiply-accumulate and 17-stage divider pipelines that form each rounded quotient.
// Reset clears only the valid bits travelling with the data.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
module quaternion_vector_rotate_core
  import qvr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [IN_TW-1:0] s_tdata,   // qx, qy, qz, qw, vx, vy, vz
  output logic m_tvalid,
  input  logic m_tready,
  output logic [OUT_TW-1:0] m_tdata,  // rx, ry, rz
  output logic [1:0] m_tuser          // zero_quat, saturated
);

  logic en;
  logic [LAT-1:0] vld;
  vec_t v_in, v_m;
  mtx_t mtx;
  divin_t dv [3];
  logic signed [DW-1:0] r [3];
  logic sat [3];
  logic zero [3];

  assign en = !vld[LAT-1] || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  assign v_in[0] = s_tdata[4*QW +: DW];
  assign v_in[1] = s_tdata[4*QW+DW +: DW];
  assign v_in[2] = s_tdata[4*QW+2*DW +: DW];

  qvr_matrix u_matrix (
    .clk   (clk),
    .en    (en),
    .qx    (s_tdata[0 +: QW]),
    .qy    (s_tdata[QW +: QW]),
    .qz    (s_tdata[2*QW +: QW]),
    .qw    (s_tdata[3*QW +: QW]),
    .v_in  (v_in),
    .mtx   (mtx),
    .v_out (v_m)
  );

  qvr_mac u_mac (
    .clk (clk),
    .en  (en),
    .mtx (mtx),
    .v   (v_m),
    .dv  (dv)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    qvr_div u_div (
      .clk  (clk),
      .en   (en),
      .din  (dv[i]),
      .r    (r[i]),
      .sat  (sat[i]),
      .zero (zero[i])
    );
  end

  assign m_tvalid = vld[LAT-1];
  assign m_tdata = OUT_TW'({r[2], r[1], r[0]});
  assign m_tuser = {sat[0] | sat[1] | sat[2], zero[0]};

endmodule

>>> src/qvr_checker.sv
// Port-level assertions for the quaternion vector rotation core, with its bind.
module qvr_checker
  import qvr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [OUT_TW-1:0] m_tdata,
  input logic [1:0] m_tuser
);

  logic signed [DW-1:0] rx, ry, rz;

  assign rx = m_tdata[0 +: DW];
  assign ry = m_tdata[DW +: DW];
  assign rz = m_tdata[2*DW +: DW];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Output transaction changed while stalled.");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("Output valid right after reset.");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> rx == '0 && ry == '0 && rz == '0 && !m_tuser[1])
    else $error("Zero quaternion result is not cleared.");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |->
      rx == DW'(DHI) || rx == -DW'(DHI) - 1'b1 ||
      ry == DW'(DHI) || ry == -DW'(DHI) - 1'b1 ||
      rz == DW'(DHI) || rz == -DW'(DHI) - 1'b1)
    else $error("Saturation flag without a clipped component.");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled while output is empty.");

endmodule

bind quaternion_vector_rotate_core qvr_checker u_qvr_checker (.*);

>>> bench/quaternion_vector_rotate_core_tb.sv
// Self-checking testbench for the quaternion vector rotation core with a rotation predictor.
`timescale 1ns / 100ps

module quaternion_vector_rotate_core_tb;
  import qvr_pkg::*;

  typedef struct {
    logic signed [QW-1:0] qx, qy, qz, qw;
    logic signed [DW-1:0] vx, vy, vz;
  } rot_in_t;

  typedef struct {
    logic signed [DW-1:0] rx, ry, rz;
    logic zero_quat;
    logic saturated;
  } rot_out_t;

  typedef struct {
    rot_in_t in;
    logic known;
    rot_out_t res;
  } vec_row_t;

  localparam int LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1900;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TW-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TW-1:0] m_tdata;
  logic [1:0] m_tuser;

  rot_out_t rotated_q[$];
  int errors = 0;
  bit sending_done = 0;
  bit long_hold = 0;
  int cycles = 0;
  vec_row_t directed[$];

  quaternion_vector_rotate_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic rot_out_t rotate_vector(rot_in_t t);
    rot_out_t r;
    longint x, y, z, w, xx, yy, zz, ww, n, a, b, qa, ra, c, val;
    longint v[3];
    longint vh[3];
    longint vl[3];
    longint m[3][3];
    longint lim;
    lim = longint'(1) <<< 46;
    x = t.qx; y = t.qy; z = t.qz; w = t.qw;
    v[0] = t.vx; v[1] = t.vy; v[2] = t.vz;
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    n = xx + yy + zz + ww;
    r.rx = 0; r.ry = 0; r.rz = 0; r.zero_quat = 0; r.saturated = 0;
    if (n == 0) begin
      r.zero_quat = 1;
      return r;
    end
    m[0][0] = ww + xx - yy - zz;
    m[0][1] = 2 * (x * y - w * z);
    m[0][2] = 2 * (x * z + w * y);
    m[1][0] = 2 * (x * y + w * z);
    m[1][1] = ww - xx + yy - zz;
    m[1][2] = 2 * (y * z - w * x);
    m[2][0] = 2 * (x * z - w * y);
    m[2][1] = 2 * (y * z + w * x);
    m[2][2] = ww - xx - yy + zz;
    for (int j = 0; j < 3; j++) begin
      vl[j] = v[j] & 64'hFFFF;
      vh[j] = floor_div(v[j] - vl[j], 65536);
    end
    for (int i = 0; i < 3; i++) begin
      a = 0; b = 0;
      for (int j = 0; j < 3; j++) begin
        a += m[i][j] * vh[j];
        b += m[i][j] * vl[j];
      end
      qa = floor_div(a, n);
      ra = a - qa * n;
      c = ra * 65536 + b;
      if (qa > lim) qa = lim;
      if (qa < -lim) qa = -lim;
      val = qa * 65536 + floor_div(2 * c + n, 2 * n);
      if (val > DHI) begin
        val = DHI; r.saturated = 1;
      end else if (val < -DHI - 1) begin
        val = -DHI - 1; r.saturated = 1;
      end
      case (i)
        0: r.rx = val[DW-1:0];
        1: r.ry = val[DW-1:0];
        default: r.rz = val[DW-1:0];
      endcase
    end
    return r;
  endfunction

  function automatic bit same_result(rot_out_t a, rot_out_t b);
    return a.rx == b.rx && a.ry == b.ry && a.rz == b.rz &&
           a.zero_quat == b.zero_quat && a.saturated == b.saturated;
  endfunction

  function automatic rot_in_t make_item(int qx, int qy, int qz, int qw, int vx, int vy, int vz);
    rot_in_t t;
    t.qx = QW'(qx); t.qy = QW'(qy); t.qz = QW'(qz); t.qw = QW'(qw);
    t.vx = DW'(vx); t.vy = DW'(vy); t.vz = DW'(vz);
    return t;
  endfunction

  function automatic rot_out_t make_result(int rx, int ry, int rz, bit zq, bit sat);
    rot_out_t r;
    r.rx = DW'(rx); r.ry = DW'(ry); r.rz = DW'(rz); r.zero_quat = zq; r.saturated = sat;
    return r;
  endfunction

  task automatic add_row(rot_in_t t, bit known, rot_out_t r);
    vec_row_t row;
    row.in = t; row.known = known; row.res = r;
    directed.push_back(row);
  endtask

  function automatic rot_in_t random_item();
    rot_in_t t;
    int kind;
    t.qx = QW'($urandom); t.qy = QW'($urandom); t.qz = QW'($urandom); t.qw = QW'($urandom);
    t.vx = DW'($urandom); t.vy = DW'($urandom); t.vz = DW'($urandom);
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      // Quaternions with random components in the range -8192 to 8192.
      t.qx = QW'($signed($urandom_range(0, 16384)) - 8192);
      t.qy = QW'($signed($urandom_range(0, 16384)) - 8192);
      t.qz = QW'($signed($urandom_range(0, 16384)) - 8192);
      t.qw = QW'($signed($urandom_range(0, 16384)) - 8192);
    end else if (kind == 4) begin
      t.qx = 0; t.qy = 0; t.qz = 0; t.qw = 0;
    end else if (kind == 5) begin
      t.qx = QW'($signed($urandom_range(0, 6)) - 3);
      t.qy = QW'($signed($urandom_range(0, 6)) - 3);
      t.qz = QW'($signed($urandom_range(0, 6)) - 3);
      t.qw = QW'($signed($urandom_range(0, 6)) - 3);
    end
    return t;
  endfunction

  task automatic send_item(rot_in_t t);
    s_tdata <= {t.vz, t.vy, t.vx, t.qw, t.qz, t.qy, t.qx};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_cycles(int k);
    s_tvalid <= 0;
    repeat (k) @(posedge clk);
  endtask

  initial begin
    rot_out_t none;
    int burst;
    int sent;
    bit drained;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    none = make_result(0, 0, 0, 0, 0);
    add_row(make_item(0, 0, 0, 0, 100, -5, 7), 1, make_result(0, 0, 0, 1, 0));
    add_row(make_item(0, 0, 0, 16384, 1234, -32768, 32767), 1,
            make_result(1234, -32768, 32767, 0, 0));
    add_row(make_item(0, 0, 0, -32768, -32768, 32767, 0), 1,
            make_result(-32768, 32767, 0, 0, 0));
    add_row(make_item(0, 0, 0, 1, -1, 1, -1), 1, make_result(-1, 1, -1, 0, 0));
    add_row(make_item(16384, 0, 0, 0, 5, 6, 7), 1, make_result(5, -6, -7, 0, 0));
    add_row(make_item(0, 16384, 0, 0, 5, 6, 7), 1, make_result(-5, 6, -7, 0, 0));
    add_row(make_item(0, 0, 16384, 0, 5, 6, 7), 1, make_result(-5, -6, 7, 0, 0));
    add_row(make_item(0, 0, -32768, 0, -32768, 0, 0), 1, make_result(32767, 0, 0, 0, 1));
    add_row(make_item(-32768, -32768, -32768, -32768, 32767, -32768, 32767), 0, none);
    add_row(make_item(32767, 32767, 32767, 32767, -32768, -32768, -32768), 0, none);
    add_row(make_item(11585, 0, 0, 11585, 32767, 32767, 32767), 0, none);
    add_row(make_item(0, 11585, 0, 11585, -32768, 100, -32768), 0, none);
    add_row(make_item(0, 0, 11585, 11585, 32767, -32768, 1), 0, none);
    add_row(make_item(1, 1, 1, 1, 3, 3, 3), 0, none);
    add_row(make_item(1, 0, 1, 0, 1, 0, 0), 0, none);
    add_row(make_item(-1, 2, -3, 1, 32767, 32767, -32768), 0, none);
    add_row(make_item(32767, -32768, 1, 0, 1, -1, 0), 0, none);
    add_row(make_item(-1, -1, -1, -1, -1, -1, -1), 0, none);
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[k]) begin
      if (directed[k].known) begin
        if (!same_result(rotate_vector(directed[k].in), directed[k].res)) begin
          $error("directed row %0d: predictor disagrees with table", k);
          errors++;
        end
        rotated_q.push_back(directed[k].res);
      end else begin
        rotated_q.push_back(rotate_vector(directed[k].in));
      end
      send_item(directed[k].in);
    end
    idle_cycles(1);
    while (rotated_q.size() != 0) @(posedge clk);
    long_hold <= 1;
    sent = 0;
    drained = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 60) long_hold <= 0;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        rot_in_t t;
        t = random_item();
        rotated_q.push_back(rotate_vector(t));
        send_item(t);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      if (sent >= 900 && !drained) begin
        drained = 1;
        idle_cycles(1);
        while (rotated_q.size() != 0) @(posedge clk);
      end
    end
    s_tvalid <= 0;
    sending_done = 1;
  end

  initial begin
    int hold_count;
    m_tready = 0;
    hold_count = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold && hold_count < 200) begin
        m_tready <= 0;
        hold_count++;
      end else if (cycles % 512 < 128) begin
        m_tready <= 1;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    rot_out_t got;
    rot_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.rx = m_tdata[DW-1:0];
      got.ry = m_tdata[2*DW-1:DW];
      got.rz = m_tdata[3*DW-1:2*DW];
      got.zero_quat = m_tuser[0];
      got.saturated = m_tuser[1];
      if (rotated_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        want = rotated_q.pop_front();
        if (got.rx !== want.rx) begin
          $error("rx: expected %0d, got %0d", want.rx, got.rx); errors++;
        end
        if (got.ry !== want.ry) begin
          $error("ry: expected %0d, got %0d", want.ry, got.ry); errors++;
        end
        if (got.rz !== want.rz) begin
          $error("rz: expected %0d, got %0d", want.rz, got.rz); errors++;
        end
        if (got.zero_quat !== want.zero_quat) begin
          $error("zero_quat: expected %0d, got %0d", want.zero_quat, got.zero_quat);
          errors++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    while (!(sending_done && rotated_q.size() == 0) && cycles < LIMIT) @(posedge clk);
    if (cycles >= LIMIT) begin
      $display("quaternion_vector_rotate_core_tb: FAIL");
    end else begin
      repeat (3 * LAT) @(posedge clk);
      if (errors == 0 && rotated_q.size() == 0) begin
        $display("quaternion_vector_rotate_core_tb: PASS");
      end else begin
        $display("quaternion_vector_rotate_core_tb: FAIL");
      end
    end
    $finish;
  end

  always @(posedge clk) cycles <= cycles + 1;

endmodule

>>> files.f
src/qvr_pkg.sv
src/qvr_matrix.sv
src/qvr_mac.sv
src/qvr_div.sv
src/quaternion_vector_rotate_core.sv
src/qvr_checker.sv
bench/quaternion_vector_rotate_core_tb.sv
